>>> rtl/cpualu_pkg.sv
// Types and constants for the condition-code ALU.
// No dependencies; imported by cpu_alu_with_condition_codes.
`timescale 1ns / 1ps

package cpualu_pkg;

   typedef enum logic [4:0] {
      OP_NEG    = 5'd0,
      OP_COM    = 5'd1,
      OP_LSR    = 5'd2,
      OP_ROR    = 5'd3,
      OP_ASR    = 5'd4,
      OP_ASL    = 5'd5,
      OP_ROL    = 5'd6,
      OP_DEC    = 5'd7,
      OP_INC    = 5'd8,
      OP_TST    = 5'd9,
      OP_CLR    = 5'd10,
      OP_SUB    = 5'd11,
      OP_SBC    = 5'd12,
      OP_AND    = 5'd13,
      OP_LD     = 5'd14,
      OP_EOR    = 5'd15,
      OP_ADC    = 5'd16,
      OP_OR     = 5'd17,
      OP_ADD    = 5'd18,
      OP_SUBW   = 5'd19,
      OP_LD16   = 5'd20,
      OP_ADDW   = 5'd21,
      OP_BRANCH = 5'd22
   } alu_op_type;

   // Branch condition pairs; low bit of the condition number inverts.
   typedef enum logic [2:0] {
      BR_ALWAYS = 3'd0,
      BR_HI     = 3'd1,
      BR_CC     = 3'd2,
      BR_NE     = 3'd3,
      BR_VC     = 3'd4,
      BR_PL     = 3'd5,
      BR_GE     = 3'd6,
      BR_GT     = 3'd7
   } br_group_type;

   // Condition-code bit positions
   localparam int unsigned FL_C = 0;
   localparam int unsigned FL_V = 1;
   localparam int unsigned FL_Z = 2;
   localparam int unsigned FL_N = 3;
   localparam int unsigned FL_H = 5;

   localparam logic [7:0] DEC_OVF = 8'h7f;
   localparam logic [7:0] INC_OVF = 8'h80;

endpackage

>>> rtl/cpu_alu_with_condition_codes.sv
// Condition-code ALU: 8/16-bit operations with flag update and branch test.
// Depends on cpualu_pkg for opcode and condition types and flag positions.
`timescale 1ns / 1ps

//  channel   ports                                         handshake
//  --------  --------------------------------------------  ------------------------
//  request   req_opcode req_operand_a req_operand_b         start && !busy
//            req_condition req_cc_in
//  response  rsp_result rsp_cc_out rsp_branch_taken         rsp_strobe, one cycle
//
//  One item per clock. A request passes the request register, then the
//  adder/flag logic feeding the response register.
//  busy is always low; the block never holds off a request.
//  reset (synchronous) clears the strobes only; data registers are not reset.
//  The receiver cannot stall; each response shows for exactly one cycle.

module cpu_alu_with_condition_codes (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [4:0]              req_opcode,
   input  logic [15:0]             req_operand_a,
   input  logic [15:0]             req_operand_b,
   input  logic [3:0]              req_condition,
   input  logic [7:0]              req_cc_in,
   output logic                    rsp_strobe,
   output logic [15:0]             rsp_result,
   output logic [7:0]              rsp_cc_out,
   output logic                    rsp_branch_taken
);

   import cpualu_pkg::*;

   // request register
   logic          req_vld_ff;
   alu_op_type    op_ff;
   logic [15:0]   a_ff;
   logic [15:0]   b_ff;
   logic [3:0]    cond_ff;
   logic [7:0]    cc_ff;

   // response register
   logic          rsp_vld_ff;
   logic [15:0]   result_ff;
   logic [7:0]    cc_out_ff;
   logic          taken_ff;

   logic [15:0]   result_in;
   logic [7:0]    cc_out_in;
   logic          taken_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start;
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= alu_op_type'(req_opcode);
         a_ff    <= req_operand_a;
         b_ff    <= req_operand_b;
         cond_ff <= req_condition;
         cc_ff   <= req_cc_in;
      end
      if (req_vld_ff) begin
         result_ff <= result_in;
         cc_out_ff <= cc_out_in;
         taken_ff  <= taken_in;
      end
   end

   always_comb begin
      logic [7:0]   a8;
      logic [7:0]   b8;
      logic         cin;
      logic [8:0]   sum9;
      logic [16:0]  sum17;
      logic         nz8;
      logic         nz16;
      logic         lt;
      logic         t;

      a8        = a_ff[7:0];
      b8        = b_ff[7:0];
      cin       = cc_ff[FL_C];
      sum9      = '0;
      sum17     = '0;
      nz8       = 1'b0;
      nz16      = 1'b0;
      result_in = '0;
      cc_out_in = cc_ff;
      taken_in  = 1'b0;
      lt        = cc_ff[FL_N] ^ cc_ff[FL_V];
      t         = 1'b1;

      unique case (op_ff) inside
         OP_NEG: begin
            sum9 = 9'd0 - {1'b0, a8};
            result_in = {8'h00, sum9[7:0]};
            cc_out_in[FL_V] = a8[7] ^ sum9[7] ^ sum9[8];
            cc_out_in[FL_C] = sum9[8];
            nz8 = 1'b1;
         end
         OP_COM: begin
            result_in = {8'h00, ~a8};
            cc_out_in[FL_V] = 1'b0;
            cc_out_in[FL_C] = 1'b1;
            nz8 = 1'b1;
         end
         OP_LSR, OP_ROR, OP_ASR: begin
            if (op_ff == OP_LSR)
               result_in = {8'h00, 1'b0, a8[7:1]};
            else if (op_ff == OP_ROR)
               result_in = {8'h00, cin, a8[7:1]};
            else
               result_in = {8'h00, a8[7], a8[7:1]};
            cc_out_in[FL_C] = a8[0];
            nz8 = 1'b1;
         end
         OP_ASL, OP_ROL: begin
            result_in = {8'h00, a8[6:0], (op_ff == OP_ROL) ? cin : 1'b0};
            cc_out_in[FL_V] = a8[7] ^ a8[6];
            cc_out_in[FL_C] = a8[7];
            nz8 = 1'b1;
         end
         OP_DEC: begin
            result_in = {8'h00, a8 - 8'd1};
            cc_out_in[FL_V] = (result_in[7:0] == DEC_OVF);
            nz8 = 1'b1;
         end
         OP_INC: begin
            result_in = {8'h00, a8 + 8'd1};
            cc_out_in[FL_V] = (result_in[7:0] == INC_OVF);
            nz8 = 1'b1;
         end
         OP_TST, OP_AND, OP_LD, OP_EOR, OP_OR: begin
            if (op_ff == OP_TST)
               result_in = {8'h00, a8};
            else if (op_ff == OP_AND)
               result_in = {8'h00, a8 & b8};
            else if (op_ff == OP_LD)
               result_in = {8'h00, b8};
            else if (op_ff == OP_EOR)
               result_in = {8'h00, a8 ^ b8};
            else
               result_in = {8'h00, a8 | b8};
            cc_out_in[FL_V] = 1'b0;
            nz8 = 1'b1;
         end
         OP_CLR: begin
            cc_out_in[FL_V] = 1'b0;
            cc_out_in[FL_C] = 1'b0;
            nz8 = 1'b1;
         end
         OP_SUB, OP_SBC: begin
            sum9 = {1'b0, a8} - {1'b0, b8}
                   - {8'h00, (op_ff == OP_SBC) ? cin : 1'b0};
            result_in = {8'h00, sum9[7:0]};
            cc_out_in[FL_V] = a8[7] ^ b8[7] ^ sum9[7] ^ sum9[8];
            cc_out_in[FL_C] = sum9[8];
            nz8 = 1'b1;
         end
         OP_ADC, OP_ADD: begin
            sum9 = {1'b0, a8} + {1'b0, b8}
                   + {8'h00, (op_ff == OP_ADC) ? cin : 1'b0};
            result_in = {8'h00, sum9[7:0]};
            cc_out_in[FL_H] = a8[4] ^ b8[4] ^ sum9[4];
            cc_out_in[FL_V] = a8[7] ^ b8[7] ^ sum9[7] ^ sum9[8];
            cc_out_in[FL_C] = sum9[8];
            nz8 = 1'b1;
         end
         OP_SUBW, OP_ADDW: begin
            if (op_ff == OP_SUBW)
               sum17 = {1'b0, a_ff} - {1'b0, b_ff};
            else
               sum17 = {1'b0, a_ff} + {1'b0, b_ff};
            result_in = sum17[15:0];
            cc_out_in[FL_V] = a_ff[15] ^ b_ff[15] ^ sum17[15] ^ sum17[16];
            cc_out_in[FL_C] = sum17[16];
            nz16 = 1'b1;
         end
         OP_LD16: begin
            result_in = b_ff;
            cc_out_in[FL_V] = 1'b0;
            nz16 = 1'b1;
         end
         OP_BRANCH: begin
            case (br_group_type'(cond_ff[3:1]))
               BR_ALWAYS: t = 1'b1;
               BR_HI:     t = ~(cc_ff[FL_C] | cc_ff[FL_Z]);
               BR_CC:     t = ~cc_ff[FL_C];
               BR_NE:     t = ~cc_ff[FL_Z];
               BR_VC:     t = ~cc_ff[FL_V];
               BR_PL:     t = ~cc_ff[FL_N];
               BR_GE:     t = ~lt;
               BR_GT:     t = ~(lt | cc_ff[FL_Z]);
            endcase
            taken_in = t ^ cond_ff[0];
         end
         default: ;  // unused opcodes: flags pass through, result is zero
      endcase

      if (nz8) begin
         cc_out_in[FL_N] = result_in[7];
         cc_out_in[FL_Z] = (result_in[7:0] == 8'h00);
      end
      if (nz16) begin
         cc_out_in[FL_N] = result_in[15];
         cc_out_in[FL_Z] = (result_in == 16'h0000);
      end
   end

   assign rsp_strobe       = rsp_vld_ff;
   assign rsp_result       = result_ff;
   assign rsp_cc_out       = cc_out_ff;
   assign rsp_branch_taken = taken_ff;

   // every response traces back to a request through the request and response registers
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("response without matching request");

   // bits outside H,N,Z,V,C always pass through
   a_cc_passthru: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cc_out[7:6] == $past(cc_ff[7:6]))
                     && (rsp_cc_out[4] == $past(cc_ff[4])))
      else $error("reserved condition bits altered");

   // branch test leaves flags alone and returns a zero result
   a_branch_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(op_ff == OP_BRANCH))
         |-> (rsp_result == 16'h0000) && (rsp_cc_out == $past(cc_ff)))
      else $error("branch test changed result or flags");

   // taken only on a branch test
   a_taken_only_branch: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(op_ff != OP_BRANCH)) |-> !rsp_branch_taken)
      else $error("branch_taken set on a non-branch item");

   // byte operations zero-extend
   a_byte_zext: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(op_ff <= OP_ADD)) |-> (rsp_result[15:8] == 8'h00))
      else $error("8-bit result not zero-extended");

endmodule
